// File: sv/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared codes and types of the rational arithmetic unit: operation codes,
// status codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_MUL   = 4'd2;
    localparam logic [3:0] OP_DIV   = 4'd3;
    localparam logic [3:0] OP_SQR   = 4'd4;
    localparam logic [3:0] OP_RECIP = 4'd5;
    localparam logic [3:0] OP_NEG   = 4'd6;
    localparam logic [3:0] OP_EQ    = 4'd7;
    localparam logic [3:0] OP_GT    = 4'd8;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZDEN = 2'd1;
    localparam logic [1:0] ST_ZZ   = 2'd2;
    localparam logic [1:0] ST_OVF  = 2'd3;

    localparam int IN_BITS  = 136;
    localparam int OUT_BITS = 72;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RINIT,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_RFIN,
        S_MUL,
        S_COMB,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        PH_A,
        PH_B,
        PH_R
    } phase_t;

endpackage

`default_nettype wire

// File: sv/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Exact arithmetic and comparison on signed fractions, results in lowest
// terms with a positive denominator.
// ----------------------------------------------------------------------------
// One item is worked on at a time; s_tready is high only while the block is
// idle. Each fraction that the opcode uses (operand A, operand B, result) is
// reduced by a binary gcd stepper (one compare/subtract or shift per cycle)
// followed by two quotients from a shared divider that retires one bit per
// cycle. Products come from one WIDTH x WIDTH multiplier used three times.
// Reserved opcodes go straight to the output state. The finished result
// sits in an output register until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_arithmetic_unit #(
    parameter int WIDTH = 32
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    // req_type[3:0], a_numerator[35:4], a_denominator[67:36],
    // b_numerator[99:68], b_denominator[131:100], zero fill
    input  wire  [rau_pkg::IN_BITS-1:0]    s_tdata,
    output logic                           m_tvalid,
    input  wire                            m_tready,
    // res_numerator[31:0], res_denominator[63:32], compare_true[64],
    // status[66:65], zero fill
    output logic [rau_pkg::OUT_BITS-1:0]   m_tdata
);
    import rau_pkg::*;

    localparam int MW = 2 * WIDTH;
    localparam int DW = MW + 1;
    localparam int CW = $clog2(MW);
    localparam logic [MW-1:0] LIM = MW'((64'd1 << (WIDTH - 1)) - 64'd1);

    state_t state_reg, state_next;
    phase_t phase_reg;

    logic [3:0]              op_reg;
    logic signed [WIDTH-1:0] inb_n_reg, inb_d_reg;
    logic signed [WIDTH-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [DW-1:0]    rn_reg, rd_reg;
    logic                    sn_reg, sd_reg;
    logic [MW-1:0]           mn_reg, md_reg, x_reg, y_reg, g_reg, q_reg;
    logic [MW:0]             rem_reg;
    logic [CW-1:0]           k_reg, cnt_reg;
    logic [1:0]              mstep_reg;
    logic signed [MW-1:0]    p0_reg, p1_reg, p2_reg;
    logic signed [WIDTH-1:0] res_n_reg, res_d_reg;
    logic                    cmp_reg;
    logic [1:0]              st_reg;
    logic                    m_tvalid_reg;
    logic [OUT_BITS-1:0]     m_tdata_reg;

    logic in_xfer, out_load, binary_op;
    logic gcd_done, div_last;
    logic [MW-1:0] gcd_val, q_new, mag_n, mag_d;
    logic [MW:0]   rem_sh, rem_new;
    logic          ovf, neg;
    logic signed [WIDTH-1:0] mx, my, fn, fd;
    logic signed [MW-1:0]    prod;
    logic signed [DW-1:0]    sum;

    assign in_xfer   = s_tvalid && s_tready;
    assign out_load  = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);
    assign binary_op = op_reg inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_EQ, OP_GT};

    // magnitudes of the fraction under reduction
    assign mag_n = rn_reg[DW-1] ? MW'(-rn_reg) : MW'(rn_reg);
    assign mag_d = rd_reg[DW-1] ? MW'(-rd_reg) : MW'(rd_reg);

    // binary gcd stepper
    assign gcd_done = (x_reg == '0) || (y_reg == '0);
    assign gcd_val  = (x_reg == '0) ? (y_reg << k_reg) : (x_reg << k_reg);

    // restoring divider, one quotient bit per cycle
    assign rem_sh   = {rem_reg[MW-1:0], q_reg[MW-1]};
    assign rem_new  = (rem_sh >= {1'b0, g_reg}) ? rem_sh - {1'b0, g_reg} : rem_sh;
    assign q_new    = {q_reg[MW-2:0], rem_sh >= {1'b0, g_reg}};
    assign div_last = cnt_reg == CW'(MW - 1);

    assign neg = (sn_reg != sd_reg) && (mn_reg != '0);
    assign ovf = (md_reg > LIM) || (mn_reg > LIM + MW'(neg));
    assign fn  = neg ? -WIDTH'(mn_reg) : WIDTH'(mn_reg);
    assign fd  = WIDTH'(md_reg);

    // multiplier operand selection
    always_comb begin
        mx = '0;
        my = '0;
        case (mstep_reg)
            2'd0: begin
                case (op_reg)
                    OP_ADD, OP_SUB, OP_DIV, OP_GT: begin mx = an_reg; my = bd_reg; end
                    OP_MUL:   begin mx = an_reg; my = bn_reg; end
                    OP_SQR:   begin mx = an_reg; my = an_reg; end
                    OP_RECIP: begin mx = ad_reg; my = WIDTH'(1); end
                    default:  begin mx = '0; my = '0; end
                endcase
            end
            2'd1: begin
                case (op_reg)
                    OP_ADD, OP_SUB, OP_GT: begin mx = bn_reg; my = ad_reg; end
                    OP_NEG:  begin mx = an_reg; my = WIDTH'(1); end
                    default: begin mx = '0; my = '0; end
                endcase
            end
            default: begin
                case (op_reg)
                    OP_ADD, OP_SUB, OP_MUL: begin mx = ad_reg; my = bd_reg; end
                    OP_DIV:   begin mx = ad_reg; my = bn_reg; end
                    OP_SQR:   begin mx = ad_reg; my = ad_reg; end
                    OP_RECIP: begin mx = an_reg; my = WIDTH'(1); end
                    OP_NEG:   begin mx = ad_reg; my = WIDTH'(1); end
                    default:  begin mx = '0; my = '0; end
                endcase
            end
        endcase
    end

    assign prod = MW'(mx) * MW'(my);
    assign sum  = (op_reg == OP_SUB || op_reg == OP_NEG)
                ? DW'(p0_reg) - DW'(p1_reg) : DW'(p0_reg) + DW'(p1_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_xfer) begin
                    state_next = (s_tdata[3:0] > OP_GT) ? S_OUT : S_RINIT;
                end
            end
            S_RINIT: state_next = (mag_d == '0) ? S_OUT : S_GCD;
            S_GCD:   if (gcd_done) state_next = S_DIVN;
            S_DIVN:  if (div_last) state_next = S_DIVD;
            S_DIVD:  if (div_last) state_next = S_RFIN;
            S_RFIN: begin
                if (ovf || phase_reg == PH_R) begin
                    state_next = S_OUT;
                end else if (phase_reg == PH_A) begin
                    state_next = binary_op ? S_RINIT : S_MUL;
                end else begin
                    state_next = (op_reg == OP_EQ) ? S_OUT : S_MUL;
                end
            end
            S_MUL:   if (mstep_reg == 2'd2) state_next = S_COMB;
            S_COMB:  state_next = (op_reg == OP_GT) ? S_OUT : S_RINIT;
            S_OUT:   if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_tready = (state_reg == S_IDLE);
        m_tvalid = m_tvalid_reg;
        m_tdata  = m_tdata_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                op_reg    <= s_tdata[3:0];
                inb_n_reg <= s_tdata[68 +: WIDTH];
                inb_d_reg <= s_tdata[100 +: WIDTH];
                rn_reg    <= DW'(signed'(s_tdata[4 +: WIDTH]));
                rd_reg    <= DW'(signed'(s_tdata[36 +: WIDTH]));
                phase_reg <= PH_A;
                res_n_reg <= '0;
                res_d_reg <= '0;
                cmp_reg   <= 1'b0;
                st_reg    <= ST_OK;
            end
            S_RINIT: begin
                mn_reg <= mag_n;
                md_reg <= mag_d;
                sn_reg <= rn_reg[DW-1];
                sd_reg <= rd_reg[DW-1];
                x_reg  <= mag_n;
                y_reg  <= mag_d;
                k_reg  <= '0;
                if (mag_d == '0) begin
                    st_reg <= (mag_n == '0) ? ST_ZZ : ST_ZDEN;
                end
            end
            S_GCD: begin
                if (gcd_done) begin
                    g_reg   <= gcd_val;
                    q_reg   <= mn_reg;
                    rem_reg <= '0;
                    cnt_reg <= '0;
                end else if (!x_reg[0] && !y_reg[0]) begin
                    x_reg <= x_reg >> 1;
                    y_reg <= y_reg >> 1;
                    k_reg <= k_reg + CW'(1);
                end else if (!x_reg[0]) begin
                    x_reg <= x_reg >> 1;
                end else if (!y_reg[0]) begin
                    y_reg <= y_reg >> 1;
                end else if (x_reg >= y_reg) begin
                    x_reg <= x_reg - y_reg;
                end else begin
                    y_reg <= y_reg - x_reg;
                end
            end
            S_DIVN: begin
                if (div_last) begin
                    mn_reg  <= q_new;
                    q_reg   <= md_reg;
                    rem_reg <= '0;
                    cnt_reg <= '0;
                end else begin
                    q_reg   <= q_new;
                    rem_reg <= rem_new;
                    cnt_reg <= cnt_reg + CW'(1);
                end
            end
            S_DIVD: begin
                if (div_last) begin
                    md_reg <= q_new;
                end else begin
                    q_reg   <= q_new;
                    rem_reg <= rem_new;
                    cnt_reg <= cnt_reg + CW'(1);
                end
            end
            S_RFIN: begin
                mstep_reg <= 2'd0;
                if (ovf) begin
                    st_reg <= ST_OVF;
                end else begin
                    case (phase_reg)
                        PH_A: begin
                            an_reg    <= fn;
                            ad_reg    <= fd;
                            rn_reg    <= DW'(inb_n_reg);
                            rd_reg    <= DW'(inb_d_reg);
                            phase_reg <= PH_B;
                        end
                        PH_B: begin
                            bn_reg  <= fn;
                            bd_reg  <= fd;
                            cmp_reg <= (op_reg == OP_EQ) && (an_reg == fn) && (ad_reg == fd);
                        end
                        default: begin
                            res_n_reg <= fn;
                            res_d_reg <= fd;
                        end
                    endcase
                end
            end
            S_MUL: begin
                mstep_reg <= mstep_reg + 2'd1;
                case (mstep_reg)
                    2'd0:    p0_reg <= prod;
                    2'd1:    p1_reg <= prod;
                    default: p2_reg <= prod;
                endcase
            end
            S_COMB: begin
                cmp_reg   <= (op_reg == OP_GT) && (p0_reg > p1_reg);
                rn_reg    <= sum;
                rd_reg    <= DW'(p2_reg);
                phase_reg <= PH_R;
            end
            S_OUT: begin
                if (out_load) begin
                    m_tdata_reg <= (st_reg == ST_OK)
                        ? {5'd0, st_reg, cmp_reg, 32'(res_d_reg), 32'(res_n_reg)}
                        : {5'd0, st_reg, 65'd0};
                end
            end
            default: begin
            end
        endcase
    end

    // an error status carries no fraction and no comparison
    a_status_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[66:65] != ST_OK |-> m_tdata[64:0] == '0)
        else $error("nonzero status with nonzero result fields");

    // a fraction result always has a nonnegative denominator and no compare flag
    a_den_positive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[63:32] != '0 |-> !m_tdata[63] && !m_tdata[64])
        else $error("bad fraction result");

    // the block is busy after taking an item
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted while busy");

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams fraction requests through the rational arithmetic unit and checks
// every result against an in-bench predictor of reduced rational arithmetic,
// with random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
`default_nettype none

class frac_scoreboard;
    logic [71:0] pending_q[$];
    int          mismatches;
    int          checked;

    function void note_request(logic [71:0] predicted);
        pending_q.push_back(predicted);
    endfunction

    function void check_result(logic [71:0] got);
        logic [71:0] want;
        if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result %h", got);
            return;
        end
        want = pending_q.pop_front();
        checked++;
        if (want[31:0] !== got[31:0] || want[63:32] !== got[63:32] ||
            want[64] !== got[64] || want[66:65] !== got[66:65] ||
            got[71:67] !== 5'd0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: num %h/%h den %h/%h cmp %b/%b st %0d/%0d",
                         want[31:0], got[31:0], want[63:32], got[63:32],
                         want[64], got[64], want[66:65], got[66:65]);
        end
    endfunction
endclass

module testbench;
    import rau_pkg::*;

    localparam int WIDTH = 32;
    localparam int LIMIT = 10_000_000;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    wire                 s_tready;
    logic [IN_BITS-1:0]  s_tdata = '0;
    wire                 m_tvalid;
    logic                m_tready = 1'b0;
    wire  [OUT_BITS-1:0] m_tdata;

    frac_scoreboard sb = new();
    int  cycles;
    int  sent;
    bit  hold_off;
    bit  drain_done;
    int  op_seen[16];

    rational_arithmetic_unit #(.WIDTH(WIDTH)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic logic signed [63:0] widen(logic [31:0] raw);
        return {{32{raw[WIDTH-1]}}, raw};
    endfunction

    // brings n/d to lowest terms; returns status
    function automatic logic [1:0] lowest_terms(logic signed [63:0] n,
            logic signed [63:0] d, output logic signed [63:0] rn,
            output logic signed [63:0] rd);
        logic [63:0] mn, md, g, lim;
        logic        neg;
        mn = n < 0 ? -n : n;
        md = d < 0 ? -d : d;
        lim = (64'd1 << (WIDTH - 1)) - 1;
        rn = 0;
        rd = 0;
        if (md == 0) return mn == 0 ? ST_ZZ : ST_ZDEN;
        g = gcd64(mn, md);
        mn = mn / g;
        md = md / g;
        neg = ((n < 0) != (d < 0)) && mn != 0;
        if (md > lim || mn > lim + (neg ? 1 : 0)) return ST_OVF;
        rn = neg ? -$signed(mn) : $signed(mn);
        rd = md;
        return ST_OK;
    endfunction

    function automatic logic [71:0] compute_fraction_result(logic [IN_BITS-1:0] req);
        logic [3:0]         op;
        logic signed [63:0] an, ad, bn, bd, rn, rd;
        logic [1:0]         st;
        logic               cmp;
        logic               binary;
        op = req[3:0];
        cmp = 1'b0;
        bn = 0;
        bd = 1;
        rn = 0;
        rd = 0;
        if (op > OP_GT) return '0;
        binary = op <= OP_DIV || op == OP_EQ || op == OP_GT;
        st = lowest_terms(widen(req[35:4]), widen(req[67:36]), an, ad);
        if (st == ST_OK && binary)
            st = lowest_terms(widen(req[99:68]), widen(req[131:100]), bn, bd);
        if (st == ST_OK) begin
            case (op)
                OP_ADD:   st = lowest_terms(an * bd + bn * ad, ad * bd, rn, rd);
                OP_SUB:   st = lowest_terms(an * bd - bn * ad, ad * bd, rn, rd);
                OP_MUL:   st = lowest_terms(an * bn, ad * bd, rn, rd);
                OP_DIV:   st = lowest_terms(an * bd, ad * bn, rn, rd);
                OP_SQR:   st = lowest_terms(an * an, ad * ad, rn, rd);
                OP_RECIP: st = lowest_terms(ad, an, rn, rd);
                OP_NEG:   st = lowest_terms(-an, ad, rn, rd);
                OP_EQ:    cmp = an == bn && ad == bd;
                default:  cmp = an * bd > bn * ad;
            endcase
        end
        if (st != ST_OK) return {5'd0, st, 1'b0, 64'd0};
        if (op <= OP_NEG) return {5'd0, ST_OK, 1'b0, rd[31:0], rn[31:0]};
        return {5'd0, ST_OK, cmp, 64'd0};
    endfunction

    function automatic logic [31:0] pick_component();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'd0;
            3: return 32'hffff_ffff;
            4: return $urandom();
            5: return $urandom_range(0, 2) == 0 ? 32'd1 : 32'hffff_ffff;
            default: return $signed($urandom_range(0, 400)) - 200;
        endcase
    endfunction

    task automatic send_request(logic [3:0] op, logic [31:0] an, logic [31:0] ad,
            logic [31:0] bn, logic [31:0] bd);
        s_tdata <= {4'd0, bd, bn, ad, an, op};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(compute_fraction_result({4'd0, bd, bn, ad, an, op}));
        op_seen[op]++;
        sent++;
        @(negedge aclk);
    endtask

    task automatic pause_sender(int n);
        s_tvalid <= 1'b0;
        repeat (n) @(negedge aclk);
    endtask

    task automatic random_request();
        logic [3:0]  op;
        logic [31:0] an, ad, bn, bd;
        op = 4'($urandom_range(0, 19) == 0 ? $urandom_range(9, 15) : $urandom_range(0, 8));
        an = pick_component();
        ad = pick_component();
        bn = pick_component();
        bd = pick_component();
        // mostly valid operands so the arithmetic paths get exercised
        if ($urandom_range(0, 9) != 0 && ad == 0) ad = 1;
        if ($urandom_range(0, 9) != 0 && bd == 0) bd = 32'hffff_fffd;
        send_request(op, an, ad, bn, bd);
    endtask

    // result side: stall pattern plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_off) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(0, 3) != 0) || (cycles % 512 > 400);
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int k;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        // directed: extremes and each special case
        send_request(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
        send_request(OP_SUB, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
        send_request(OP_MUL, 32'h8000_0000, 32'd1, 32'hffff_ffff, 32'd1);
        send_request(OP_DIV, 32'd3, 32'd4, 32'd0, 32'd5);
        send_request(OP_DIV, 32'd0, 32'd4, 32'd0, 32'd5);
        send_request(OP_SQR, 32'h7fff_ffff, 32'd1, 32'd0, 32'd0);
        send_request(OP_RECIP, 32'd0, 32'd7, 32'd0, 32'd0);
        send_request(OP_RECIP, 32'hffff_fffd, 32'd6, 32'd0, 32'd0);
        send_request(OP_NEG, 32'h8000_0000, 32'd1, 32'd0, 32'd0);
        send_request(OP_NEG, 32'd4, 32'h8000_0000, 32'd0, 32'd0);
        send_request(OP_EQ, 32'd2, 32'd4, 32'hffff_ffff, 32'hffff_fffe);
        send_request(OP_EQ, 32'd2, 32'd4, 32'd1, 32'd3);
        send_request(OP_GT, 32'd1, 32'd3, 32'd1, 32'd4);
        send_request(OP_GT, 32'h8000_0000, 32'd1, 32'h7fff_ffff, 32'd1);
        send_request(OP_ADD, 32'd5, 32'd0, 32'd1, 32'd1);
        send_request(OP_ADD, 32'd0, 32'd0, 32'd1, 32'd1);
        send_request(OP_ADD, 32'd1, 32'd1, 32'd5, 32'd0);
        send_request(OP_MUL, 32'd1, 32'd1, 32'd0, 32'd0);
        send_request(OP_ADD, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
        send_request(OP_SUB, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff);
        send_request(4'd9, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_request(4'd15, 32'd0, 32'd0, 32'd0, 32'd0);
        send_request(OP_DIV, 32'h8000_0000, 32'd1, 32'hffff_ffff, 32'd1);
        // hold off the result side while requests keep coming
        hold_off = 1'b1;
        fork
            begin
                repeat (3000) @(negedge aclk);
                hold_off = 1'b0;
            end
            for (k = 0; k < 6; k++) random_request();
        join
        // random part in bursts
        while (sent < 1300) begin
            for (k = $urandom_range(1, 12); k > 0; k--) random_request();
            if ($urandom_range(0, 1) == 0) pause_sender($urandom_range(1, 40));
            if ($urandom_range(0, 30) == 0) begin
                s_tvalid <= 1'b0;
                while (sb.pending_q.size() != 0) @(negedge aclk);
            end
        end
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(negedge aclk);
        repeat (500) @(negedge aclk);
        $display("covered %0d requests, %0d results checked; per opcode add %0d sub %0d",
                 sent, sb.checked, op_seen[0], op_seen[1]);
        $display("mul %0d div %0d sqr %0d recip %0d neg %0d eq %0d gt %0d",
                 op_seen[2], op_seen[3], op_seen[4], op_seen[5], op_seen[6],
                 op_seen[7], op_seen[8]);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("tb: failure");
        end
        $finish;
    end
endmodule

`default_nettype wire

// File: rational_arithmetic_unit.f
sv/rau_pkg.sv
sv/rational_arithmetic_unit.sv
tb/testbench.sv
